// ----- hdl/grfc_pkg.sv -----
// shared types and constants for the gated reciprocal frequency counter
// no dependencies

package grfc_pkg;

  localparam int DEFAULT_COUNT_BITS = 16;

  localparam int TICKS_W   = 8;
  localparam int ELAPSED_W = 32;
  localparam int MIN_W     = 16;
  localparam int FREQ_W    = 32;
  localparam int EDGES_W   = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // ticks_per_us * 1e6 fits in 28 bits for any 8-bit tick rate
  localparam int SCALE_W = 28;

  localparam logic [TICKS_W-1:0]   TICKS_RESET = 8'd72;
  localparam logic [ELAPSED_W-1:0] GATE_RESET  = 32'd72000000;
  localparam logic [MIN_W-1:0]     MIN_RESET   = 16'd5;
  localparam logic [SCALE_W-1:0]   US_PER_S    = 28'd1000000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [FREQ_W-1:0]    FREQ_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKS = 2'd0,
    CFG_GATE  = 2'd1,
    CFG_MIN   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    STOP_FULL = 1'b0,
    STOP_GATE = 1'b1
  } stop_kind_t;

  // what the measurement side hands over on a stop
  typedef struct packed {
    stop_kind_t           kind;
    logic                 zero;
    logic [ELAPSED_W-1:0] elapsed;
  } stop_t;

  // controller to datapath commands
  typedef struct packed {
    logic scale;
    logic mul;
    logic load;
    logic step;
    logic emit;
  } cmd_t;

endpackage

// ----- hdl/grfc_meas.sv -----
// measurement front end: edge and cycle counters with stop detection
// depends on grfc_pkg

module grfc_meas #(
  parameter int COUNT_BITS = grfc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           edge_req,
  input  logic                           restart,
  input  logic [grfc_pkg::ELAPSED_W-1:0] gate_cycles,
  input  logic [grfc_pkg::MIN_W-1:0]     min_count,
  output logic                           stop,
  output grfc_pkg::stop_t                info,
  output logic [COUNT_BITS-1:0]          num
);

  import grfc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_DONE
  } phase_t;

  phase_t                phase;
  logic [COUNT_BITS-1:0] edge_counter;
  logic [ELAPSED_W-1:0]  elapsed_cycles;

  logic                  start;
  logic                  running;
  logic [COUNT_BITS-1:0] cnt0;
  logic [COUNT_BITS-1:0] cnt1;
  logic [ELAPSED_W-1:0]  el0;
  logic [ELAPSED_W-1:0]  el1;
  logic                  full;
  logic                  gate;

  always_comb begin
    start   = restart || (phase == PH_IDLE);
    running = start || (phase == PH_RUN);
    cnt0    = start ? '0 : edge_counter;
    el0     = start ? '0 : elapsed_cycles;
    el1     = (el0 == ELAPSED_MAX) ? el0 : el0 + ELAPSED_W'(1);
    cnt1    = edge_req ? cnt0 + COUNT_BITS'(1) : cnt0;
    // counter full wins over the gate in the same cycle
    full    = running && edge_req && (cnt1 == '0);
    gate    = running && !full && ((el1 > gate_cycles) || (el1 == ELAPSED_MAX));
  end

  assign stop         = accept && (full || gate);
  assign num          = full ? '1 : cnt1;
  assign info.kind    = gate ? STOP_GATE : STOP_FULL;
  assign info.zero    = gate && (32'(cnt1) <= 32'(min_count));
  assign info.elapsed = el1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      edge_counter   <= '0;
      elapsed_cycles <= '0;
    end else if (accept && running) begin
      edge_counter   <= cnt1;
      elapsed_cycles <= el1;
      phase          <= (full || gate) ? PH_DONE : PH_RUN;
    end
  end

endmodule

// ----- hdl/grfc_ctrl.sv -----
// sequencer for the post-stop arithmetic and the result word handshake
// depends on grfc_pkg

module grfc_ctrl #(
  parameter int DIV_STEPS = grfc_pkg::DEFAULT_COUNT_BITS + grfc_pkg::SCALE_W + 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           result_stall,
  output logic           busy,
  output logic           result_valid,
  output grfc_pkg::cmd_t cmd
);

  import grfc_pkg::*;

  localparam int SW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t        state;
  logic [SW-1:0] step_cnt;
  logic          emit;

  assign emit = (state == ST_FIN) && (!result_valid || !result_stall);
  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.scale = (state == ST_SCALE);
    cmd.mul   = (state == ST_MUL);
    cmd.load  = (state == ST_LOAD);
    cmd.step  = (state == ST_DIV);
    cmd.emit  = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_MUL;
        ST_MUL:   state <= ST_LOAD;
        ST_LOAD: begin
          step_cnt <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (step_cnt == SW'(DIV_STEPS - 1)) begin
            state <= ST_FIN;
          end else begin
            step_cnt <= step_cnt + SW'(1);
          end
        end
        ST_FIN: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/grfc_dp.sv -----
// operand capture, scale multiply, restoring divider and result registers
// depends on grfc_pkg

module grfc_dp #(
  parameter int COUNT_BITS = grfc_pkg::DEFAULT_COUNT_BITS,
  parameter int DIV_STEPS  = grfc_pkg::DEFAULT_COUNT_BITS + grfc_pkg::SCALE_W + 2
) (
  input  logic                         clk,
  input  logic                         capture,
  input  grfc_pkg::stop_t              info,
  input  logic [COUNT_BITS-1:0]        num,
  input  logic [grfc_pkg::TICKS_W-1:0] ticks_per_us,
  input  grfc_pkg::cmd_t               cmd,
  output logic [grfc_pkg::FREQ_W-1:0]    frequency_hz,
  output logic                           stop_kind,
  output logic [grfc_pkg::EDGES_W-1:0]   edges_counted,
  output logic [grfc_pkg::ELAPSED_W-1:0] cycles_elapsed
);

  import grfc_pkg::*;

  localparam int PW = COUNT_BITS + SCALE_W;
  localparam int NW = DIV_STEPS;
  localparam int DW = ELAPSED_W + 1;

  stop_t                 info_r;
  logic [COUNT_BITS-1:0] num_r;
  logic [TICKS_W-1:0]    tpu_r;
  logic [SCALE_W-1:0]    scale_r;
  logic [PW-1:0]         prod_r;
  logic [NW-1:0]         quo;
  logic [DW-1:0]         rem;

  logic [DW-1:0]         den;
  logic [DW:0]           trial;
  logic                  ge;
  logic [NW-1:0]         dividend;
  logic                  sat;

  always_comb begin
    // 2*elapsed, and 2*count*scale + elapsed for the rounded gate case
    den      = {info_r.elapsed, 1'b0};
    trial    = {rem, quo[NW-1]};
    ge       = (trial >= {1'b0, den});
    dividend = NW'({prod_r, 1'b0})
             + NW'((info_r.kind == STOP_GATE) ? info_r.elapsed : '0);
    sat      = |quo[NW-1:FREQ_W];
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      info_r <= info;
      num_r  <= num;
      tpu_r  <= ticks_per_us;
    end
    if (cmd.scale) begin
      scale_r <= SCALE_W'(tpu_r) * US_PER_S;
    end
    if (cmd.mul) begin
      prod_r <= PW'(num_r) * PW'(scale_r);
    end
    if (cmd.load) begin
      quo <= dividend;
      rem <= '0;
    end else if (cmd.step) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
    end
    if (cmd.emit) begin
      frequency_hz   <= info_r.zero ? '0 : (sat ? FREQ_MAX : quo[FREQ_W-1:0]);
      stop_kind      <= info_r.kind;
      edges_counted  <= EDGES_W'(num_r);
      cycles_elapsed <= info_r.elapsed;
    end
  end

endmodule

// ----- hdl/gated_reciprocal_frequency_counter.sv -----
// gated reciprocal frequency counter, top level
// one input word per reference cycle while counting; counting words go in back to back
// a stopping word stalls the input while the scale, multiply, load, restoring divide and finish
// states run, plus any wait for a held result word; the new result word follows
// synchronous active-high reset: idle, counters cleared, registers to defaults
// depends on grfc_pkg, grfc_meas, grfc_ctrl, grfc_dp

module gated_reciprocal_frequency_counter #(
  parameter int COUNT_BITS = grfc_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [grfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [grfc_pkg::CFG_W-1:0]     cfg_data,
  // item channel, one word per reference cycle while item_stall is low
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           edge_req,
  input  logic                           restart,
  // result channel
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [grfc_pkg::FREQ_W-1:0]    frequency_hz,
  output logic                           stop_kind,
  output logic [grfc_pkg::EDGES_W-1:0]   edges_counted,
  output logic [grfc_pkg::ELAPSED_W-1:0] cycles_elapsed
);

  import grfc_pkg::*;

  // dividend is 2*count*scale, plus elapsed on a gate stop, one quotient bit per divider step
  localparam int DIV_STEPS = COUNT_BITS + SCALE_W + 2;

  logic [TICKS_W-1:0]   ticks_per_us;
  logic [ELAPSED_W-1:0] gate_cycles;
  logic [MIN_W-1:0]     min_count;

  logic                  accept;
  logic                  stop;
  stop_t                 info;
  logic [COUNT_BITS-1:0] num;
  logic                  busy;
  cmd_t                  cmd;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= TICKS_RESET;
      gate_cycles  <= GATE_RESET;
      min_count    <= MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TICKS: ticks_per_us <= cfg_data[TICKS_W-1:0];
        CFG_GATE:  gate_cycles  <= cfg_data[ELAPSED_W-1:0];
        CFG_MIN:   min_count    <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input is held off only while the arithmetic after a stop runs and its result waits to go out;
  // a pending result word does not block counting
  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;

  grfc_meas #(
    .COUNT_BITS (COUNT_BITS)
  ) u_meas (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .edge_req    (edge_req),
    .restart     (restart),
    .gate_cycles (gate_cycles),
    .min_count   (min_count),
    .stop        (stop),
    .info        (info),
    .num         (num)
  );

  grfc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (stop),
    .result_stall (result_stall),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  grfc_dp #(
    .COUNT_BITS (COUNT_BITS),
    .DIV_STEPS  (DIV_STEPS)
  ) u_dp (
    .clk            (clk),
    .capture        (stop),
    .info           (info),
    .num            (num),
    .ticks_per_us   (ticks_per_us),
    .cmd            (cmd),
    .frequency_hz   (frequency_hz),
    .stop_kind      (stop_kind),
    .edges_counted  (edges_counted),
    .cycles_elapsed (cycles_elapsed)
  );

`ifndef SYNTHESIS
  // a stopping word always starts the divider
  a_stop_starts_div: assert property (@(posedge clk) disable iff (rst)
    stop |=> item_stall)
    else $error("stop did not start the divider");

  // a new result word only follows a divider run
  a_result_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result word without a divider run");

  // a counter-full stop always reports the full count
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (stop_kind == STOP_FULL)) |->
      (edges_counted == EDGES_W'({COUNT_BITS{1'b1}})))
    else $error("counter-full result with wrong edge count");
`endif

endmodule
